// File: rtl/core/sequential_key_list_defines.svh
// Assertion macros shared by the sequential key list RTL.
`ifndef SEQUENTIAL_KEY_LIST_DEFINES_SVH
`define SEQUENTIAL_KEY_LIST_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SKL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequential key list check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SKL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequential key list check failed");

`endif

// File: rtl/core/skl_pkg.sv
// Package with the action and status codes and the cell control type.
`default_nettype none
package skl_pkg;

  localparam int KeyWidth    = 32;
  localparam int ActionWidth = 2;
  localparam int StatusWidth = 3;
  localparam int PosWidth    = 5;
  localparam int CapWidth    = 5;

  localparam logic [ActionWidth-1:0] ACT_SEARCH = 2'd0;
  localparam logic [ActionWidth-1:0] ACT_INSERT = 2'd1;
  localparam logic [ActionWidth-1:0] ACT_REMOVE = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
  localparam logic [StatusWidth-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [StatusWidth-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [StatusWidth-1:0] ST_UNDERFLOW = 3'd4;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rm;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/skl_cell.sv
// One list cell: holds a key, compares it, loads the request key on insert and shifts from its upper neighbour.
`default_nettype none
module skl_cell
  import skl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int IDX         = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cell_ctl_t                            ctl,
  input  logic [KeyWidth-1:0]                  req_key,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     count,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     rm_pos,
  input  logic [KeyWidth-1:0]                  next_key,
  output logic [KeyWidth-1:0]                  key,
  output logic                                 hit
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic live;
  logic ins_here;
  logic shift_here;

  assign live       = CW'(IDX) < count;
  assign ins_here   = ctl.ins && (count == CW'(IDX));
  assign shift_here = ctl.rm && (CW'(IDX + 1) >= rm_pos);

  // The match is held until the next compare, so a stalled decision still sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.cmp) begin
      hit <= live && (key == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ins_here) begin
      key <= req_key;
    end else if (shift_here) begin
      key <= next_key;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sequential_key_list.sv
// Each item passes through two states: the compare in every cell, then the decision and update.
// An item may be accepted in the cycle that the previous one finishes, so a new item
// can enter its compare while the output register drains; a waiting result stalls it.
// Reset empties the list, sets the capacity limit to 16 and clears all handshake state.
// The cell keys are not reset; entries beyond the fill count are never used.
`default_nettype none
`include "sequential_key_list_defines.svh"
module sequential_key_list
  import skl_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CapWidth-1:0]           cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ActionWidth-1:0]        action,
  input  logic signed [KeyWidth-1:0]    key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [StatusWidth-1:0]        status,
  output logic [PosWidth-1:0]           position,
  output logic [PosWidth-1:0]           entry_count
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > CapWidth) ? CW : CapWidth;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DEC
  } state_t;

  state_t                 state;
  logic [ActionWidth-1:0] req_action;
  logic [KeyWidth-1:0]    req_key;
  logic [CW-1:0]          count;
  logic [CapWidth-1:0]    cap_limit;

  logic [MAX_ENTRIES-1:0] hits;
  logic [KeyWidth-1:0]    cell_key [MAX_ENTRIES];
  logic [CW-1:0]          hit_pos;
  logic                   found;
  logic                   full;
  logic                   finish;
  logic                   accept;
  cell_ctl_t              ctl;

  logic [StatusWidth-1:0] status_next;
  logic [CW-1:0]          pos_next;
  logic [CW-1:0]          count_next;
  logic                   do_ins;
  logic                   do_rm;

  assign finish   = (state == S_DEC) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE) || finish;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hits[i]) begin
        hit_pos = hit_pos | CW'(i + 1);
      end
    end
  end

  assign found = |hits;
  assign full  = (LW'(count) >= LW'(cap_limit)) || (LW'(count) >= LW'(MAX_ENTRIES));

  always_comb begin
    status_next = found ? ST_OK : ST_NOT_FOUND;
    pos_next    = hit_pos;
    count_next  = count;
    do_ins      = 1'b0;
    do_rm       = 1'b0;
    case (req_action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_OVERFLOW;
          pos_next    = '0;
        end else if (found) begin
          status_next = ST_DUPLICATE;
        end else begin
          status_next = ST_OK;
          count_next  = count + CW'(1);
          pos_next    = count + CW'(1);
          do_ins      = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (count == '0) begin
          status_next = ST_UNDERFLOW;
          pos_next    = '0;
        end else if (found) begin
          status_next = ST_OK;
          count_next  = count - CW'(1);
          do_rm       = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = found ? ST_OK : ST_NOT_FOUND;
      end
    endcase
  end

  assign ctl.cmp = (state == S_CMP);
  assign ctl.ins = finish && do_ins;
  assign ctl.rm  = finish && do_rm;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [KeyWidth-1:0] upper_key;
    if (g == MAX_ENTRIES - 1) begin : g_last
      assign upper_key = cell_key[g];
    end else begin : g_mid
      assign upper_key = cell_key[g+1];
    end
    skl_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .req_key  (req_key),
      .count    (count),
      .rm_pos   (hit_pos),
      .next_key (upper_key),
      .key      (cell_key[g]),
      .hit      (hits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap_limit <= CapWidth'(16);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      if (finish) begin
        out_valid   <= 1'b1;
        status      <= status_next;
        position    <= PosWidth'(pos_next);
        entry_count <= PosWidth'(count_next);
        count       <= count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_DEC;
        end
        S_DEC: begin
          if (finish) begin
            state <= accept ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
    end
  end

  `SKL_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES))
  `SKL_ASSERT_SAME(a_single_hit, clk, rst, state == S_DEC, $onehot0(hits))
  `SKL_ASSERT_NEXT(a_finish_shows, clk, rst, finish, out_valid)
  `SKL_ASSERT_NEXT(a_cmp_then_dec, clk, rst, state == S_CMP, state == S_DEC)
  `SKL_ASSERT_NEXT(a_accept_cmp, clk, rst, accept, state == S_CMP)

endmodule
`default_nettype wire
